>>> src/pwt_pkg.sv
// shared types and constants for the polygon winding test
package pwt_pkg;

  // port field widths
  localparam int COORD_W      = 32;
  localparam int WIND_OUT_W   = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // parameter defaults
  localparam int COORD_BITS_DEF   = 32;
  localparam int WINDING_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEST_X    = 2'd0,
    REG_TEST_Y    = 2'd1,
    REG_EVEN_ODD  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      final_vertex;
  } vertex_t;

  typedef struct packed {
    logic                         inside_res;
    logic signed [WIND_OUT_W-1:0] winding_sum;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_wr_t;

  // per edge crossing candidates, before the product compare
  typedef struct packed {
    logic up;
    logic dn;
  } edge_flags_t;

endpackage

>>> src/pwt_vertex_if.sv
// vertex channel
interface pwt_vertex_if;
  logic             valid;
  logic             ready;
  pwt_pkg::vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pwt_result_if.sv
// result channel
interface pwt_result_if;
  logic             valid;
  logic             ready;
  pwt_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pwt_cfg_if.sv
// configuration write channel
interface pwt_cfg_if;
  logic             valid;
  logic             ready;
  pwt_pkg::cfg_wr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pwt_cfg_regs.sv
// configuration registers: hit point and fill rule
module pwt_cfg_regs #(
  parameter int COORD_BITS = pwt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pwt_cfg_if.sink                      cfg,
  output logic signed [COORD_BITS-1:0] test_x,
  output logic signed [COORD_BITS-1:0] test_y,
  output logic                         even_odd
);

  logic signed [COORD_BITS-1:0] test_x_r;
  logic signed [COORD_BITS-1:0] test_y_r;
  logic                         even_odd_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_x_r   <= '0;
      test_y_r   <= '0;
      even_odd_r <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_idx)
        pwt_pkg::REG_TEST_X:   test_x_r   <= COORD_BITS'(cfg.data.wr_data);
        pwt_pkg::REG_TEST_Y:   test_y_r   <= COORD_BITS'(cfg.data.wr_data);
        pwt_pkg::REG_EVEN_ODD: even_odd_r <= cfg.data.wr_data[0];
        default: ;
      endcase
    end
  end

  assign test_x   = test_x_r;
  assign test_y   = test_y_r;
  assign even_odd = even_odd_r;

endmodule

>>> src/pwt_edge_mul.sv
// one edge: span tests and the two cross products, registered
module pwt_edge_mul #(
  parameter int COORD_BITS = pwt_pkg::COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output pwt_pkg::edge_flags_t         flags,
  output logic signed [PW-1:0]         lhs,
  output logic signed [PW-1:0]         rhs
);

  logic signed [DW-1:0] dx, dy, ex, ey;
  logic signed [PW-1:0] lhs_nxt, rhs_nxt;
  pwt_pkg::edge_flags_t flags_nxt;
  pwt_pkg::edge_flags_t flags_r;
  logic signed [PW-1:0] lhs_r, rhs_r;

  always_comb begin
    dx = DW'(x1) - DW'(x0);
    dy = DW'(y1) - DW'(y0);
    ex = DW'(px) - DW'(x0);
    ey = DW'(py) - DW'(y0);
    lhs_nxt = PW'(ex) * PW'(dy);
    rhs_nxt = PW'(ey) * PW'(dx);
    // horizontal edges never count
    flags_nxt.up = en && !dy[DW-1] && (dy != '0) && (py >= y0) && (py < y1);
    flags_nxt.dn = en && dy[DW-1] && (py >= y1) && (py < y0);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= flags_nxt;
      lhs_r   <= lhs_nxt;
      rhs_r   <= rhs_nxt;
    end
  end

  assign flags = flags_r;
  assign lhs   = lhs_r;
  assign rhs   = rhs_r;

endmodule

>>> src/pwt_wind_acc.sv
// winding sum: product compare, saturating update and result register
module pwt_wind_acc #(
  parameter int COORD_BITS   = pwt_pkg::COORD_BITS_DEF,
  parameter int WINDING_BITS = pwt_pkg::WINDING_BITS_DEF,
  localparam int PW = 2 * (COORD_BITS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 final_vertex,
  input  logic                 enough_verts,
  input  logic                 even_odd,
  input  pwt_pkg::edge_flags_t flags_a,
  input  logic signed [PW-1:0] lhs_a,
  input  logic signed [PW-1:0] rhs_a,
  input  pwt_pkg::edge_flags_t flags_b,
  input  logic signed [PW-1:0] lhs_b,
  input  logic signed [PW-1:0] rhs_b,
  output logic                 out_free,
  pwt_result_if.source         res
);

  localparam logic signed [WINDING_BITS-1:0] ACC_MAX = {1'b0, {(WINDING_BITS-1){1'b1}}};
  localparam logic signed [WINDING_BITS-1:0] ACC_MIN = {1'b1, {(WINDING_BITS-1){1'b0}}};
  localparam logic signed [WINDING_BITS-1:0] ACC_ONE = WINDING_BITS'(1);

  logic signed [WINDING_BITS-1:0] acc_r, acc_mid, acc_end;
  logic                           inc_a, dec_a, inc_b, dec_b;
  logic                           out_v_r;
  pwt_pkg::result_t               out_data_r, out_data_nxt;

  always_comb begin
    inc_a = flags_a.up && (lhs_a >= rhs_a);
    dec_a = flags_a.dn && (lhs_a <= rhs_a);
    inc_b = flags_b.up && (lhs_b >= rhs_b);
    dec_b = flags_b.dn && (lhs_b <= rhs_b);

    // edges apply in order, each clamped on its own
    acc_mid = acc_r;
    if (inc_a && acc_r != ACC_MAX) acc_mid = acc_r + ACC_ONE;
    if (dec_a && acc_r != ACC_MIN) acc_mid = acc_r - ACC_ONE;
    acc_end = acc_mid;
    if (inc_b && acc_mid != ACC_MAX) acc_end = acc_mid + ACC_ONE;
    if (dec_b && acc_mid != ACC_MIN) acc_end = acc_mid - ACC_ONE;

    out_data_nxt.winding_sum = pwt_pkg::WIND_OUT_W'(acc_end);
    if (!enough_verts) out_data_nxt.inside_res = 1'b0;
    else if (even_odd)  out_data_nxt.inside_res = acc_end[0];
    else                out_data_nxt.inside_res = (acc_end != '0);
  end

  assign out_free = !out_v_r || res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (step) begin
        acc_r <= final_vertex ? '0 : acc_end;
      end
      if (step && final_vertex) begin
        out_v_r    <= 1'b1;
        out_data_r <= out_data_nxt;
      end else if (res.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign res.valid = out_v_r;
  assign res.data  = out_data_r;

endmodule

>>> src/polygon_point_winding_test_core.sv
// top level: streaming point-in-polygon test by winding number, nonzero or even-odd rule
//
//  channel  | dir | payload                                 | handshake
//  ---------+-----+-----------------------------------------+------------
//  in_vtx   | in  | vertex_x, vertex_y, final_vertex        | valid/ready
//  out_res  | out | inside_res, winding_sum                 | valid/ready
//  cfg_wr   | in  | reg_idx, wr_data                        | valid/ready
//
// one vertex per cycle unless a stalled result backs up the pipe; three register stages
// (input, products, result) lie between a final vertex's beat and its result.
// rst_n is synchronous and clears the vertex count, the winding sum and all valids.
// cfg_wr is always ready. a stalled result only holds back final vertices behind it;
// other vertices keep flowing until the two inner stages fill.
module polygon_point_winding_test_core #(
  parameter int COORD_BITS   = pwt_pkg::COORD_BITS_DEF,
  parameter int WINDING_BITS = pwt_pkg::WINDING_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pwt_vertex_if.sink   in_vtx,
  pwt_result_if.source out_res,
  pwt_cfg_if.sink      cfg_wr
);

  localparam int PW = 2 * (COORD_BITS + 1);

  logic signed [COORD_BITS-1:0] test_x, test_y;
  logic                         even_odd;

  logic signed [COORD_BITS-1:0] vx, vy;
  logic                         accept;

  // polygon tracking at the input side
  logic [1:0]                   seen_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;

  // input stage
  logic                         s1_v_r, s1_final_r, s1_enough_r, s1_en_a_r;
  logic signed [COORD_BITS-1:0] s1_prev_x_r, s1_prev_y_r, s1_x_r, s1_y_r;
  logic signed [COORD_BITS-1:0] s1_first_x_r, s1_first_y_r;

  // product stage
  logic                         s2_v_r, s2_final_r, s2_enough_r;

  logic                         s1_go, s1_adv, s2_go, s2_adv, out_free;
  pwt_pkg::edge_flags_t         flags_a, flags_b;
  logic signed [PW-1:0]         lhs_a, rhs_a, lhs_b, rhs_b;

  pwt_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_wr),
    .test_x   (test_x),
    .test_y   (test_y),
    .even_odd (even_odd)
  );

  assign vx = COORD_BITS'(in_vtx.data.vertex_x);
  assign vy = COORD_BITS'(in_vtx.data.vertex_y);

  assign s2_go  = !s2_final_r || out_free;
  assign s2_adv = s2_v_r && s2_go;
  assign s1_go  = !s2_v_r || s2_go;
  assign s1_adv = s1_v_r && s1_go;

  assign in_vtx.ready = !s1_v_r || s1_go;
  assign accept       = in_vtx.valid && in_vtx.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_vtx.data.final_vertex) seen_r <= '0;
        else if (seen_r != 2'd3)      seen_r <= seen_r + 2'd1;
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv)      s2_v_r <= 1'b1;
      else if (s2_adv) s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_r == '0) begin
        first_x_r <= vx;
        first_y_r <= vy;
      end
      prev_x_r    <= vx;
      prev_y_r    <= vy;
      s1_x_r      <= vx;
      s1_y_r      <= vy;
      s1_prev_x_r <= prev_x_r;
      s1_prev_y_r <= prev_y_r;
      // the closing edge of a lone vertex goes back to itself
      s1_first_x_r <= (seen_r == '0) ? vx : first_x_r;
      s1_first_y_r <= (seen_r == '0) ? vy : first_y_r;
      s1_en_a_r    <= (seen_r != '0);
      s1_final_r   <= in_vtx.data.final_vertex;
      s1_enough_r  <= seen_r[1];
    end
    if (s1_adv) begin
      s2_final_r  <= s1_final_r;
      s2_enough_r <= s1_enough_r;
    end
  end

  // edge from the previous vertex
  pwt_edge_mul #(.COORD_BITS(COORD_BITS)) u_edge_a (
    .clk   (clk),
    .load  (s1_adv),
    .en    (s1_en_a_r),
    .x0    (s1_prev_x_r),
    .y0    (s1_prev_y_r),
    .x1    (s1_x_r),
    .y1    (s1_y_r),
    .px    (test_x),
    .py    (test_y),
    .flags (flags_a),
    .lhs   (lhs_a),
    .rhs   (rhs_a)
  );

  // closing edge back to the first vertex
  pwt_edge_mul #(.COORD_BITS(COORD_BITS)) u_edge_b (
    .clk   (clk),
    .load  (s1_adv),
    .en    (s1_final_r),
    .x0    (s1_x_r),
    .y0    (s1_y_r),
    .x1    (s1_first_x_r),
    .y1    (s1_first_y_r),
    .px    (test_x),
    .py    (test_y),
    .flags (flags_b),
    .lhs   (lhs_b),
    .rhs   (rhs_b)
  );

  pwt_wind_acc #(
    .COORD_BITS   (COORD_BITS),
    .WINDING_BITS (WINDING_BITS)
  ) u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s2_adv),
    .final_vertex (s2_final_r),
    .enough_verts (s2_enough_r),
    .even_odd     (even_odd),
    .flags_a      (flags_a),
    .lhs_a        (lhs_a),
    .rhs_a        (rhs_a),
    .flags_b      (flags_b),
    .lhs_b        (lhs_b),
    .rhs_b        (rhs_b),
    .out_free     (out_free),
    .res          (out_res)
  );

endmodule
